@@ hw/rtl/smpp_pkg.sv @@
// Shared types, constants and lookup functions for the SMPP PDU field parser.
package smpp_pkg;

  localparam int ShortMsgMax = 254;
  localparam int HeaderBytes = 16;
  localparam int MaxPduBytes = 4096;

  localparam logic [4:0] TagTrail    = 5'd31;
  localparam logic [4:0] TagSmLen    = 5'd27;
  localparam logic [4:0] TagShortMsg = 5'd28;
  localparam logic [4:0] StepHalt    = 5'd31;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBadLen  = 3'd1;
  localparam logic [2:0] StBadSys  = 3'd2;
  localparam logic [2:0] StBadPass = 3'd3;
  localparam logic [2:0] StBadFld  = 3'd4;
  localparam logic [2:0] StBadCmd  = 3'd5;

  localparam logic [2:0] RegSysId      = 3'd0;
  localparam logic [2:0] RegPassword   = 3'd1;
  localparam logic [2:0] RegSysType    = 3'd2;
  localparam logic [2:0] RegAddrRange  = 3'd3;
  localparam logic [2:0] RegSvcType    = 3'd4;
  localparam logic [2:0] RegAddress    = 3'd5;
  localparam logic [2:0] RegTimeString = 3'd6;
  localparam logic [2:0] RegMessageId  = 3'd7;

  typedef enum logic [2:0] {
    LayBind, LayBindRsp, LaySubmit, LayDeliver, LayMsgId, LayNone, LayUnknown
  } layout_t;

  // Map a command id to a body layout.
  function automatic layout_t layout_of(input logic [31:0] cmd);
    layout_t lay;
    case (cmd)
      32'h0000_0001, 32'h0000_0002: lay = LayBind;
      32'h8000_0001, 32'h8000_0002: lay = LayBindRsp;
      32'h0000_0004:                lay = LaySubmit;
      32'h0000_0005:                lay = LayDeliver;
      32'h8000_0004, 32'h8000_0005: lay = LayMsgId;
      32'h8000_0000, 32'h0000_0015, 32'h8000_0015: lay = LayNone;
      default:                      lay = LayUnknown;
    endcase
    return lay;
  endfunction

  // Number of body fields for a layout.
  function automatic logic [4:0] body_len(input layout_t lay);
    logic [4:0] n;
    case (lay)
      LayBind:    n = 5'd7;
      LayBindRsp: n = 5'd1;
      LaySubmit:  n = 5'd18;
      LayDeliver: n = 5'd18;
      LayMsgId:   n = 5'd1;
      default:    n = 5'd0;
    endcase
    return n;
  endfunction

  // Field tag for a body step.
  function automatic logic [4:0] body_tag(input layout_t lay, input logic [4:0] step);
    logic [4:0] t;
    case (lay)
      LayBind:    t = step + 5'd4;
      LayBindRsp: t = 5'd4;
      LaySubmit:  t = step + 5'd11;
      LayDeliver: t = step + 5'd11;
      LayMsgId:   t = 5'd29;
      default:    t = TagTrail;
    endcase
    return t;
  endfunction

  // Error code when a field fails.
  function automatic logic [2:0] fail_code(input layout_t lay, input logic [4:0] tag,
                                           input logic is_str);
    logic [2:0] c;
    case (lay)
      LayBind:    c = (tag == 5'd4) ? StBadSys : ((tag == 5'd5) ? StBadPass : StBadFld);
      LayBindRsp: c = StBadSys;
      LayMsgId:   c = StBadFld;
      default:    c = is_str ? StBadFld : StBadLen;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/smpp_pdu_field_parser_top.sv @@
// Top level of the SMPP PDU field parser: byte-wise header and body parsing.
// Takes one PDU byte per cycle while in_stall is low and returns one tagged result
// per byte from a single result register, in the cycle after the byte is accepted.
// A new PDU starts after the byte marked last. String fields are checked against the
// eight length registers, sm_length against SHORT_MSG_MAX; status carries the error
// code, where a length error replaces an earlier one, and is final with pdu_done.
module smpp_pdu_field_parser_top #(
  parameter int SHORT_MSG_MAX = smpp_pkg::ShortMsgMax,
  parameter int MAX_PDU_BYTES = smpp_pkg::MaxPduBytes
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] pdu_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] field_tag,
  output logic [7:0] field_value_byte,
  output logic [7:0] offset_in_field,
  output logic       is_terminator,
  output logic [2:0] status,
  output logic       pdu_done
);

  localparam int CntW = $clog2(MAX_PDU_BYTES + 1);

  logic [7:0] max_reg [8];

  logic [CntW-1:0] byte_count;
  logic [31:0] header_shift, stated_length, command_word;
  logic [4:0]  field_step;
  logic [7:0]  string_length, short_msg_left;
  logic [2:0]  error_code;

  logic [CntW-1:0] byte_count_next;
  logic [31:0] header_shift_next, stated_length_next, command_word_next;
  logic [4:0]  field_step_next;
  logic [7:0]  string_length_next, short_msg_left_next;
  logic [2:0]  error_code_next;

  logic [4:0] tag;
  logic [7:0] off;
  logic       term;

  logic accept;
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_reg[smpp_pkg::RegSysId]      <= 8'd15;
      max_reg[smpp_pkg::RegPassword]   <= 8'd8;
      max_reg[smpp_pkg::RegSysType]    <= 8'd12;
      max_reg[smpp_pkg::RegAddrRange]  <= 8'd40;
      max_reg[smpp_pkg::RegSvcType]    <= 8'd5;
      max_reg[smpp_pkg::RegAddress]    <= 8'd20;
      max_reg[smpp_pkg::RegTimeString] <= 8'd16;
      max_reg[smpp_pkg::RegMessageId]  <= 8'd64;
    end else if (cfg_we) begin
      max_reg[cfg_index] <= cfg_data;
    end
  end

  // Parse one byte.
  always_comb begin
    smpp_pkg::layout_t lay;
    logic [4:0] blen, btag, ftag;
    logic       is_str;
    logic [7:0] smax;
    logic [CntW:0] i1;
    logic       in_hdr;

    header_shift_next   = header_shift;
    stated_length_next  = stated_length;
    command_word_next   = command_word;
    field_step_next     = field_step;
    string_length_next  = string_length;
    short_msg_left_next = short_msg_left;
    error_code_next     = error_code;
    tag  = smpp_pkg::TagTrail;
    off  = 8'd0;
    term = 1'b0;
    is_str = 1'b0;
    smax = 8'd0;
    btag = smpp_pkg::TagTrail;
    ftag = smpp_pkg::TagTrail;
    i1 = {1'b0, byte_count} + 1'b1;
    in_hdr = (byte_count < CntW'(smpp_pkg::HeaderBytes));
    lay = smpp_pkg::layout_of(command_word);

    if (in_hdr) begin
      tag = 5'(byte_count[3:2]);
      off = 8'(byte_count[1:0]);
      header_shift_next = {header_shift[23:0], pdu_byte};
      if (byte_count == CntW'(3)) stated_length_next = header_shift_next;
      if (byte_count == CntW'(7)) begin
        command_word_next = header_shift_next;
        lay = smpp_pkg::layout_of(header_shift_next);
        if (error_code == smpp_pkg::StOk && lay == smpp_pkg::LayUnknown)
          error_code_next = smpp_pkg::StBadCmd;
      end
    end
    if ((byte_count >= CntW'(3) && 33'(i1) > {1'b0, stated_length_next}) ||
        byte_count >= CntW'(MAX_PDU_BYTES))
      error_code_next = smpp_pkg::StBadLen;
    byte_count_next = (byte_count < CntW'(MAX_PDU_BYTES)) ? i1[CntW-1:0] : byte_count;

    blen = smpp_pkg::body_len(lay);
    if (!in_hdr) begin
      if (error_code_next != smpp_pkg::StOk && field_step < blen) begin
        field_step_next = smpp_pkg::StepHalt;
        string_length_next = 8'd0;
      end
      if (lay < smpp_pkg::LayNone && field_step_next < blen) begin
        btag = smpp_pkg::body_tag(lay, field_step_next);
        tag = btag;
        off = string_length;
        case (btag)
          5'd4:  begin is_str = 1'b1; smax = max_reg[smpp_pkg::RegSysId]; end
          5'd5:  begin is_str = 1'b1; smax = max_reg[smpp_pkg::RegPassword]; end
          5'd6:  begin is_str = 1'b1; smax = max_reg[smpp_pkg::RegSysType]; end
          5'd10: begin is_str = 1'b1; smax = max_reg[smpp_pkg::RegAddrRange]; end
          5'd11: begin is_str = 1'b1; smax = max_reg[smpp_pkg::RegSvcType]; end
          5'd14, 5'd17: begin is_str = 1'b1; smax = max_reg[smpp_pkg::RegAddress]; end
          5'd21, 5'd22: begin
            is_str = (lay == smpp_pkg::LaySubmit);
            smax = max_reg[smpp_pkg::RegTimeString];
          end
          5'd29: begin is_str = 1'b1; smax = max_reg[smpp_pkg::RegMessageId]; end
          default: begin is_str = 1'b0; smax = 8'd0; end
        endcase
        if (is_str) begin
          if (pdu_byte == 8'd0) begin
            term = 1'b1;
            field_step_next = field_step_next + 5'd1;
            string_length_next = 8'd0;
          end else if ({1'b0, string_length} + 9'd1 > {1'b0, smax}) begin
            error_code_next = smpp_pkg::fail_code(lay, btag, 1'b1);
            field_step_next = smpp_pkg::StepHalt;
            string_length_next = 8'd0;
          end else begin
            string_length_next = string_length + 8'd1;
          end
        end else if (btag == smpp_pkg::TagSmLen) begin
          if (pdu_byte > 8'(SHORT_MSG_MAX)) begin
            error_code_next = smpp_pkg::StBadLen;
            field_step_next = smpp_pkg::StepHalt;
            string_length_next = 8'd0;
          end else begin
            short_msg_left_next = pdu_byte;
            field_step_next = field_step_next + ((pdu_byte == 8'd0) ? 5'd2 : 5'd1);
            string_length_next = 8'd0;
          end
        end else if (btag == smpp_pkg::TagShortMsg) begin
          short_msg_left_next = short_msg_left - 8'd1;
          if (short_msg_left_next == 8'd0) begin
            field_step_next = field_step_next + 5'd1;
            string_length_next = 8'd0;
          end else begin
            string_length_next = string_length + 8'd1;
          end
        end else begin
          field_step_next = field_step_next + 5'd1;
          string_length_next = 8'd0;
        end
      end else begin
        tag = smpp_pkg::TagTrail;
        off = string_length_next;
        if (string_length_next < 8'd255) string_length_next = string_length_next + 8'd1;
      end
    end

    // Close the PDU on the last byte.
    if (last_byte) begin
      if (i1 < (CntW+1)'(smpp_pkg::HeaderBytes)) begin
        error_code_next = smpp_pkg::StBadLen;
      end else if (error_code_next == smpp_pkg::StOk && lay < smpp_pkg::LayNone &&
                   field_step_next < blen) begin
        ftag = smpp_pkg::body_tag(lay, field_step_next);
        error_code_next = smpp_pkg::fail_code(lay, ftag,
          (ftag == 5'd4) || (ftag == 5'd5) || (ftag == 5'd6) || (ftag == 5'd10) ||
          (ftag == 5'd11) || (ftag == 5'd14) || (ftag == 5'd17) || (ftag == 5'd29) ||
          (((ftag == 5'd21) || (ftag == 5'd22)) && lay == smpp_pkg::LaySubmit));
      end
    end
  end

  // Advance parse state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      header_shift <= '0;
      stated_length <= '0;
      command_word <= '0;
      field_step <= '0;
      string_length <= '0;
      short_msg_left <= '0;
      error_code <= smpp_pkg::StOk;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          byte_count <= '0;
          header_shift <= '0;
          stated_length <= '0;
          command_word <= '0;
          field_step <= '0;
          string_length <= '0;
          short_msg_left <= '0;
          error_code <= smpp_pkg::StOk;
        end else begin
          byte_count <= byte_count_next;
          header_shift <= header_shift_next;
          stated_length <= stated_length_next;
          command_word <= command_word_next;
          field_step <= field_step_next;
          string_length <= string_length_next;
          short_msg_left <= short_msg_left_next;
          error_code <= error_code_next;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      field_tag <= tag;
      field_value_byte <= pdu_byte;
      offset_in_field <= off;
      is_terminator <= term;
      status <= error_code_next;
      pdu_done <= last_byte;
    end
  end

  // Checks on the parse state.
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    error_code <= smpp_pkg::StBadCmd) else $error("error code out of range");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> byte_count == '0 && error_code == smpp_pkg::StOk)
    else $error("state not cleared after last byte");
  a_term_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_terminator |-> field_value_byte == 8'd0)
    else $error("terminator on nonzero byte");
  a_hdr_tag: assert property (@(posedge clk) disable iff (rst)
    accept && byte_count < CntW'(smpp_pkg::HeaderBytes) |=> field_tag < 5'd4)
    else $error("header byte mis-tagged");

endmodule
